### rtl/core/h264_sps_header_parser_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef H264_SPS_HEADER_PARSER_MACROS_SVH
`define H264_SPS_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, gated by reset.
`define SHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shp check failed");

// Next-cycle implication, gated by reset.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shp check failed");

`endif

### rtl/core/shp_pkg.sv
`timescale 1ns / 1ps
package shp_pkg;

  // Byte queue between the front and the back.
  localparam int QDEPTH = 2;

  localparam logic [7:0] EP_BYTE  = 8'h03;
  localparam logic [4:0] NAL_SPS  = 5'd7;
  localparam logic [7:0] PRF_HI   = 8'd100;
  localparam logic [7:0] PRF_HI10 = 8'd110;
  localparam logic [7:0] PRF_HI42 = 8'd122;
  localparam logic [7:0] PRF_HI44 = 8'd144;
  localparam logic [7:0] AR_EXT   = 8'd255;

  // One classified byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } q_ent_t;

endpackage

### rtl/core/shp_front.sv
`timescale 1ns / 1ps
`include "h264_sps_header_parser_macros.svh"
module shp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            q_full,
  output logic            q_push,
  output shp_pkg::q_ent_t q_ent
);
  import shp_pkg::*;

  logic [1:0] zr_r, zr_nxt;
  logic       drop;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign drop      = (zr_r == 2'd2) && (in_tdata == EP_BYTE);

  // classify the beat as a prevention byte or payload
  assign q_ent.data = in_tdata;
  assign q_ent.last = in_tlast;
  assign q_ent.drop = drop;

  // track the run of zero bytes, restart per unit
  always_comb begin
    zr_nxt = zr_r;
    if (in_tlast || drop) begin
      zr_nxt = 2'd0;
    end else if (in_tdata == 8'd0) begin
      zr_nxt = (zr_r == 2'd2) ? 2'd2 : zr_r + 2'd1;
    end else begin
      zr_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zr_r <= 2'd0;
    end else if (q_push) begin
      zr_r <= zr_nxt;
    end
  end

  `SHP_ASSERT_NOW(a_drop_run, clk, rst_n, q_push && q_ent.drop, zr_r == 2'd2)
  `SHP_ASSERT_NOW(a_run_max, clk, rst_n, 1'b1, zr_r != 2'd3)

endmodule

### rtl/core/shp_queue.sv
`timescale 1ns / 1ps
`include "h264_sps_header_parser_macros.svh"
module shp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  shp_pkg::q_ent_t wr_ent,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output shp_pkg::q_ent_t rd_ent
);
  import shp_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  q_ent_t            mem_r [QDEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;

  assign full      = (cnt_r == (AW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_ent    = mem_r[rp_r];

  // hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_ent;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `SHP_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop)
  `SHP_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, not_empty)

endmodule

### rtl/core/shp_back.sv
`timescale 1ns / 1ps
`include "h264_sps_header_parser_macros.svh"
module shp_back #(
  parameter int MB_DIM_BITS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  shp_pkg::q_ent_t q_ent,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            o_is_sps,
  output logic [14:0]     o_width,
  output logic [14:0]     o_height,
  output logic [31:0]     o_rate,
  output logic [7:0]      o_profile,
  output logic [7:0]      o_level,
  output logic [4:0]      o_set_id,
  output logic            o_trunc
);
  import shp_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_SHIFT, B_DIV, B_EMIT} b_st_t;
  typedef enum logic [5:0] {
    S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_RESID, S_BDL,
    S_BDC, S_QPBYP, S_MATRIX, S_LISTFLAG, S_DELTA, S_LOG2FN, S_POCTYPE,
    S_POCLSB, S_DPOAZ, S_OFFNR, S_OFFTB, S_CYCLE, S_OFFREF, S_NUMREF, S_GAPS,
    S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_D8, S_CROP, S_CROPOFF, S_VUI,
    S_ARFLAG, S_ARIDC, S_SAR, S_OVSC, S_OVSCAPP, S_VST, S_VFMT, S_COLOUR,
    S_CHLOC, S_CHTOP, S_CHBOT, S_TIMING, S_UNITS, S_SCALE, S_FIXED, S_DONE
  } p_st_t;

  localparam logic [31:0] PX_MAX = 32'h7fff;

  function automatic logic [14:0] px_of(input logic [31:0] v);
    logic [MB_DIM_BITS:0]   mbs;
    logic [MB_DIM_BITS+4:0] px;
    if (v >= (32'd1 << MB_DIM_BITS)) begin
      mbs = {1'b1, {MB_DIM_BITS{1'b0}}};
    end else begin
      mbs = {1'b0, v[MB_DIM_BITS-1:0]} + {{MB_DIM_BITS{1'b0}}, 1'b1};
    end
    px = {mbs, 4'b0000};
    if (32'(px) > PX_MAX) begin
      return 15'h7fff;
    end
    return 15'(px);
  endfunction

  b_st_t        bst_r;
  logic [7:0]   sh_r;
  logic [2:0]   bcnt_r;
  logic         last_r;
  logic [4:0]   dcnt_r;
  logic [31:0]  rem_r;
  logic [31:0]  rate_r;

  p_st_t        pst_r, pst_nxt;
  logic         eg_r, eg_nxt, sfx_r, sfx_nxt;
  logic [5:0]   bl_r, bl_nxt, lz_r, lz_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic [7:0]   loop_r, loop_nxt;
  logic [6:0]   pos_r, pos_nxt;
  logic [7:0]   slast_r, slast_nxt;
  logic         sps_r, sps_nxt;
  logic [7:0]   prof_r, prof_nxt, lvl_r, lvl_nxt;
  logic [4:0]   sid_r, sid_nxt;
  logic [14:0]  wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic [31:0]  units_r, units_nxt, scale_r, scale_nxt;
  logic         sdone_r, sdone_nxt, fixed_r, fixed_nxt;

  logic         bit_en, b, cdone, go, go_ue;
  logic [31:0]  cval;
  p_st_t        go_st;
  logic [5:0]   go_n;
  logic [7:0]   delta, snext;
  logic [6:0]   lsize;
  logic [32:0]  rem_sh;
  logic [31:0]  div_q;
  logic [31:0]  div_r;
  logic         emit_fire;

  assign bit_en    = (bst_r == B_SHIFT);
  assign b         = sh_r[7];
  assign q_pop     = (bst_r == B_IDLE) && q_valid;
  assign emit_fire = (bst_r == B_EMIT) && (!out_tvalid || out_tready);

  // one syntax bit: field assembly, exp-Golomb decode, element walk
  always_comb begin
    pst_nxt = pst_r; eg_nxt = eg_r; sfx_nxt = sfx_r; bl_nxt = bl_r;
    lz_nxt = lz_r; acc_nxt = acc_r; loop_nxt = loop_r; pos_nxt = pos_r;
    slast_nxt = slast_r; sps_nxt = sps_r; prof_nxt = prof_r; lvl_nxt = lvl_r;
    sid_nxt = sid_r; wid_nxt = wid_r; hgt_nxt = hgt_r; units_nxt = units_r;
    scale_nxt = scale_r; sdone_nxt = sdone_r; fixed_nxt = fixed_r;
    cdone = 1'b0; cval = '0; go = 1'b0; go_ue = 1'b0; go_st = pst_r; go_n = '0;
    delta = '0; snext = '0; lsize = '0;
    if (bit_en && pst_r != S_DONE) begin
      if (!eg_r) begin
        acc_nxt = {acc_r[30:0], b};
        bl_nxt  = bl_r - 6'd1;
        if (bl_r == 6'd1) begin
          cdone = 1'b1;
          cval  = acc_nxt;
        end
      end else if (!sfx_r) begin
        if (!b) begin
          if (lz_r != 6'd63) lz_nxt = lz_r + 6'd1;
        end else if (lz_r == 6'd0) begin
          cdone = 1'b1;
        end else begin
          sfx_nxt = 1'b1;
          bl_nxt  = lz_r;
          acc_nxt = '0;
        end
      end else begin
        acc_nxt = {acc_r[30:0], b};
        bl_nxt  = bl_r - 6'd1;
        if (bl_r == 6'd1) begin
          cdone = 1'b1;
          cval  = lz_r[5] ? 32'hffff_ffff
                          : (32'd1 << lz_r[4:0]) - 32'd1 + acc_nxt;
        end
      end

      if (cdone) begin
        go = 1'b1;
        unique case (pst_r)
          S_HDR: begin
            if (cval[4:0] == NAL_SPS) begin
              sps_nxt = 1'b1; go_st = S_PROFILE; go_n = 6'd8;
            end else begin
              go = 1'b0; pst_nxt = S_DONE;
            end
          end
          S_PROFILE: begin prof_nxt = cval[7:0]; go_st = S_CONSTR; go_n = 6'd8; end
          S_CONSTR: begin go_st = S_LEVEL; go_n = 6'd8; end
          S_LEVEL: begin lvl_nxt = cval[7:0]; go_st = S_SPSID; go_ue = 1'b1; end
          S_SPSID: begin
            sid_nxt = (cval > 32'd31) ? 5'd31 : cval[4:0];
            go_ue = 1'b1;
            if (prof_r == PRF_HI || prof_r == PRF_HI10 ||
                prof_r == PRF_HI42 || prof_r == PRF_HI44) begin
              go_st = S_CHROMA;
            end else begin
              go_st = S_LOG2FN;
            end
          end
          S_CHROMA: begin
            if (cval == 32'd3) begin go_st = S_RESID; go_n = 6'd1; end
            else begin go_st = S_BDL; go_ue = 1'b1; end
          end
          S_RESID: begin go_st = S_BDL; go_ue = 1'b1; end
          S_BDL: begin go_st = S_BDC; go_ue = 1'b1; end
          S_BDC: begin go_st = S_QPBYP; go_n = 6'd1; end
          S_QPBYP: begin go_st = S_MATRIX; go_n = 6'd1; end
          S_MATRIX: begin
            if (cval[0]) begin loop_nxt = '0; go_st = S_LISTFLAG; go_n = 6'd1; end
            else begin go_st = S_LOG2FN; go_ue = 1'b1; end
          end
          S_LISTFLAG: begin
            if (cval[0]) begin
              slast_nxt = 8'd8; pos_nxt = '0; go_st = S_DELTA; go_ue = 1'b1;
            end else begin
              loop_nxt = loop_r + 8'd1;
              if (loop_r < 8'd7) begin go_st = S_LISTFLAG; go_n = 6'd1; end
              else begin go_st = S_LOG2FN; go_ue = 1'b1; end
            end
          end
          S_DELTA: begin
            delta   = cval[0] ? cval[8:1] + 8'd1 : 8'd0 - cval[8:1];
            snext   = slast_r + delta;
            lsize   = (loop_r < 8'd6) ? 7'd16 : 7'd64;
            pos_nxt = pos_r + 7'd1;
            if (snext != 8'd0) slast_nxt = snext;
            if (snext == 8'd0 || pos_nxt >= lsize) begin
              loop_nxt = loop_r + 8'd1;
              if (loop_r < 8'd7) begin go_st = S_LISTFLAG; go_n = 6'd1; end
              else begin go_st = S_LOG2FN; go_ue = 1'b1; end
            end else begin
              go_st = S_DELTA; go_ue = 1'b1;
            end
          end
          S_LOG2FN: begin go_st = S_POCTYPE; go_ue = 1'b1; end
          S_POCTYPE: begin
            if (cval == 32'd0) begin go_st = S_POCLSB; go_ue = 1'b1; end
            else if (cval == 32'd1) begin go_st = S_DPOAZ; go_n = 6'd1; end
            else begin go_st = S_NUMREF; go_ue = 1'b1; end
          end
          S_POCLSB: begin go_st = S_NUMREF; go_ue = 1'b1; end
          S_DPOAZ: begin go_st = S_OFFNR; go_ue = 1'b1; end
          S_OFFNR: begin go_st = S_OFFTB; go_ue = 1'b1; end
          S_OFFTB: begin go_st = S_CYCLE; go_ue = 1'b1; end
          S_CYCLE: begin
            loop_nxt = (cval > 32'd255) ? 8'hff : cval[7:0];
            go_ue = 1'b1;
            go_st = (loop_nxt == 8'd0) ? S_NUMREF : S_OFFREF;
          end
          S_OFFREF: begin
            loop_nxt = loop_r - 8'd1;
            go_ue = 1'b1;
            go_st = (loop_nxt == 8'd0) ? S_NUMREF : S_OFFREF;
          end
          S_NUMREF: begin go_st = S_GAPS; go_n = 6'd1; end
          S_GAPS: begin go_st = S_WIDTH; go_ue = 1'b1; end
          S_WIDTH: begin wid_nxt = px_of(cval); go_st = S_HEIGHT; go_ue = 1'b1; end
          S_HEIGHT: begin hgt_nxt = px_of(cval); go_st = S_FMO; go_n = 6'd1; end
          S_FMO: begin go_st = cval[0] ? S_D8 : S_MBAFF; go_n = 6'd1; end
          S_MBAFF: begin go_st = S_D8; go_n = 6'd1; end
          S_D8: begin go_st = S_CROP; go_n = 6'd1; end
          S_CROP: begin
            if (cval[0]) begin loop_nxt = 8'd4; go_st = S_CROPOFF; go_ue = 1'b1; end
            else begin go_st = S_VUI; go_n = 6'd1; end
          end
          S_CROPOFF: begin
            loop_nxt = loop_r - 8'd1;
            if (loop_nxt == 8'd0) begin go_st = S_VUI; go_n = 6'd1; end
            else begin go_st = S_CROPOFF; go_ue = 1'b1; end
          end
          S_VUI: begin
            if (cval[0]) begin go_st = S_ARFLAG; go_n = 6'd1; end
            else begin go = 1'b0; pst_nxt = S_DONE; end
          end
          S_ARFLAG: begin
            if (cval[0]) begin go_st = S_ARIDC; go_n = 6'd8; end
            else begin go_st = S_OVSC; go_n = 6'd1; end
          end
          S_ARIDC: begin
            if (cval[7:0] == AR_EXT) begin go_st = S_SAR; go_n = 6'd32; end
            else begin go_st = S_OVSC; go_n = 6'd1; end
          end
          S_SAR: begin go_st = S_OVSC; go_n = 6'd1; end
          S_OVSC: begin go_st = cval[0] ? S_OVSCAPP : S_VST; go_n = 6'd1; end
          S_OVSCAPP: begin go_st = S_VST; go_n = 6'd1; end
          S_VST: begin
            if (cval[0]) begin go_st = S_VFMT; go_n = 6'd5; end
            else begin go_st = S_CHLOC; go_n = 6'd1; end
          end
          S_VFMT: begin
            if (cval[0]) begin go_st = S_COLOUR; go_n = 6'd24; end
            else begin go_st = S_CHLOC; go_n = 6'd1; end
          end
          S_COLOUR: begin go_st = S_CHLOC; go_n = 6'd1; end
          S_CHLOC: begin
            if (cval[0]) begin go_st = S_CHTOP; go_ue = 1'b1; end
            else begin go_st = S_TIMING; go_n = 6'd1; end
          end
          S_CHTOP: begin go_st = S_CHBOT; go_ue = 1'b1; end
          S_CHBOT: begin go_st = S_TIMING; go_n = 6'd1; end
          S_TIMING: begin
            if (cval[0]) begin go_st = S_UNITS; go_n = 6'd32; end
            else begin go = 1'b0; pst_nxt = S_DONE; end
          end
          S_UNITS: begin units_nxt = cval; go_st = S_SCALE; go_n = 6'd32; end
          S_SCALE: begin
            scale_nxt = cval; sdone_nxt = 1'b1; go_st = S_FIXED; go_n = 6'd1;
          end
          S_FIXED: begin fixed_nxt = cval[0]; go = 1'b0; pst_nxt = S_DONE; end
          default: begin go = 1'b0; pst_nxt = S_DONE; end
        endcase

        // enter the next element
        if (go) begin
          pst_nxt = go_st;
          eg_nxt  = go_ue;
          sfx_nxt = 1'b0;
          bl_nxt  = go_n;
          acc_nxt = '0;
          if (go_ue) lz_nxt = '0;
        end
      end
    end
  end

  // one restoring division step
  always_comb begin
    rem_sh = {rem_r, scale_r[31]};
    if (rem_sh >= {1'b0, units_r}) begin
      div_r = 32'(rem_sh - {1'b0, units_r});
      div_q = {scale_r[30:0], 1'b1};
    end else begin
      div_r = rem_sh[31:0];
      div_q = {scale_r[30:0], 1'b0};
    end
  end

  // sequencer, parse registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n || emit_fire) begin
      pst_r <= S_HDR; eg_r <= 1'b0; sfx_r <= 1'b0; bl_r <= 6'd8; lz_r <= '0;
      acc_r <= '0; loop_r <= '0; pos_r <= '0; slast_r <= 8'd8; sps_r <= 1'b0;
      prof_r <= '0; lvl_r <= '0; sid_r <= '0; wid_r <= '0; hgt_r <= '0;
      units_r <= '0; scale_r <= '0; sdone_r <= 1'b0; fixed_r <= 1'b0;
      bst_r <= B_IDLE;
    end
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      bcnt_r     <= '0;
      dcnt_r     <= '0;
    end else begin
      if (out_tready && !emit_fire) out_tvalid <= 1'b0;
      unique case (bst_r)
        B_IDLE: begin
          if (q_valid) begin
            sh_r   <= q_ent.data;
            last_r <= q_ent.last;
            bcnt_r <= '0;
            if (!q_ent.drop) begin
              bst_r <= B_SHIFT;
            end else if (q_ent.last) begin
              rem_r  <= '0;
              dcnt_r <= '0;
              rate_r <= '0;
              bst_r  <= (sdone_r && units_r != '0) ? B_DIV : B_EMIT;
            end
          end
        end
        B_SHIFT: begin
          pst_r <= pst_nxt; eg_r <= eg_nxt; sfx_r <= sfx_nxt; bl_r <= bl_nxt;
          lz_r <= lz_nxt; acc_r <= acc_nxt; loop_r <= loop_nxt;
          pos_r <= pos_nxt; slast_r <= slast_nxt; sps_r <= sps_nxt;
          prof_r <= prof_nxt; lvl_r <= lvl_nxt; sid_r <= sid_nxt;
          wid_r <= wid_nxt; hgt_r <= hgt_nxt; units_r <= units_nxt;
          scale_r <= scale_nxt; sdone_r <= sdone_nxt; fixed_r <= fixed_nxt;
          sh_r   <= {sh_r[6:0], 1'b0};
          bcnt_r <= bcnt_r + 3'd1;
          if (bcnt_r == 3'd7) begin
            if (last_r) begin
              rem_r  <= '0;
              dcnt_r <= '0;
              rate_r <= '0;
              bst_r  <= (sdone_nxt && units_nxt != '0) ? B_DIV : B_EMIT;
            end else begin
              bst_r <= B_IDLE;
            end
          end
        end
        B_DIV: begin
          rem_r   <= div_r;
          scale_r <= div_q;
          dcnt_r  <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd31) begin
            rate_r <= fixed_r ? {1'b0, div_q[31:1]} : div_q;
            bst_r  <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (emit_fire) begin
            out_tvalid <= 1'b1;
            o_is_sps   <= sps_r;
            o_width    <= wid_r;
            o_height   <= hgt_r;
            o_rate     <= rate_r;
            o_profile  <= prof_r;
            o_level    <= lvl_r;
            o_set_id   <= sid_r;
            o_trunc    <= (pst_r != S_DONE);
          end
        end
        default: bst_r <= B_IDLE;
      endcase
    end
  end

  `SHP_ASSERT_NOW(a_div_nonzero, clk, rst_n, bst_r == B_DIV, units_r != '0)
  `SHP_ASSERT_NOW(a_pop_idle, clk, rst_n, q_pop, bst_r == B_IDLE)
  `SHP_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_fire, pst_r == S_HDR && !sps_r)

endmodule

### rtl/core/h264_sps_header_parser.sv
// Flow: a kept byte is popped from the queue, then parsed in 8 bit-serial parse steps;
// a dropped prevention byte is only popped. After the last byte the rate divider runs
// when timing info has nonzero units, then the result goes into the output register.
// Throughput is one bit per cycle in the parse unit, which pops a byte only while idle.
// Reset: rst_n is synchronous, active low; the parser returns to the NAL header element.
`timescale 1ns / 1ps
module h264_sps_header_parser #(
  parameter int MB_DIM_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] nal_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // width_pixels, height_pixels, frame_rate, profile,
                                  // level, set_id, truncated, zero fill
  output logic        out_tuser   // is_sps
);
  import shp_pkg::*;

  q_ent_t      f_ent, b_ent;
  logic        q_push, q_full, q_pop, q_nempty;
  logic        o_trunc;
  logic [14:0] o_width, o_height;
  logic [31:0] o_rate;
  logic [7:0]  o_profile, o_level;
  logic [4:0]  o_set_id;

  shp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .q_full(q_full), .q_push(q_push), .q_ent(f_ent)
  );

  shp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wr_ent(f_ent), .full(q_full),
    .pop(q_pop), .not_empty(q_nempty), .rd_ent(b_ent)
  );

  shp_back #(.MB_DIM_BITS(MB_DIM_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_nempty), .q_ent(b_ent), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .o_is_sps(out_tuser), .o_width(o_width), .o_height(o_height),
    .o_rate(o_rate), .o_profile(o_profile), .o_level(o_level),
    .o_set_id(o_set_id), .o_trunc(o_trunc)
  );

  // pack the result beat
  assign out_tdata = {4'b0000, o_trunc, o_set_id, o_level, o_profile,
                      o_rate, o_height, o_width};

endmodule

### verif/tb_h264_sps_header_parser.sv
`timescale 1ns / 1ps
module tb_h264_sps_header_parser;
  import shp_pkg::*;

  // Syntax elements walked by the predictor
  typedef enum logic [5:0] {
    ST_HDR = 6'd0, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_RESID,
    ST_BDL, ST_BDC, ST_QPBYP, ST_MATRIX, ST_LISTFLAG, ST_DELTA, ST_LOG2FN, ST_POCTYPE,
    ST_POCLSB, ST_DPOAZ, ST_OFFNR, ST_OFFTB, ST_CYCLE, ST_OFFREF, ST_NUMREF, ST_GAPS,
    ST_WIDTH, ST_HEIGHT, ST_FMO, ST_MBAFF, ST_D8, ST_CROP, ST_CROPOFF, ST_VUI,
    ST_ARFLAG, ST_ARIDC, ST_SAR, ST_OVSC, ST_OVSCAPP, ST_VST, ST_VFMT, ST_COLOUR,
    ST_CHLOC, ST_CHTOP, ST_CHBOT, ST_TIMING, ST_UNITS, ST_SCALE, ST_FIXED,
    ST_DONE = 6'd63
  } sps_elem_e;

  localparam int MB_BITS = 10;

  typedef struct packed {
    logic        is_sps;
    logic [14:0] width_px;
    logic [14:0] height_px;
    logic [31:0] rate;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [4:0]  set_id;
    logic        truncated;
  } sps_info_t;

  // Knobs for building one SPS unit
  typedef struct {
    logic [7:0]  profile;
    int          chroma;
    bit          matrix;
    int          poc_type;
    int          cycle_len;
    logic [31:0] set_id;
    logic [31:0] wmb;
    logic [31:0] hmb;
    bit          crop;
    bit          vui;
    bit          ar;
    logic [7:0]  ar_idc;
    bit          vst;
    bit          colour;
    bit          chloc;
    bit          timing;
    logic [31:0] units;
    logic [31:0] tscale;
    bit          fixed;
    int          cut;
    int          junk;
  } sps_knobs_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tuser;

  h264_sps_header_parser #(.MB_DIM_BITS(MB_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  sps_info_t   info_q[$];
  int          errors = 0;
  int          units_sent = 0;
  int          sps_seen = 0;
  int          cut_seen = 0;
  int          bytes_sent = 0;
  bit          no_idle = 1'b0;
  logic [7:0]  unit_bytes[$];
  bit          bitq[$];

  // Predictor state
  logic [1:0]  p_zeros;
  sps_elem_e   p_elem;
  logic [3:0]  p_unused;
  logic [7:0]  p_left;
  logic [5:0]  p_lz;
  logic [31:0] p_acc;
  logic [7:0]  p_loop;
  logic [7:0]  p_pos;
  logic [7:0]  p_last_sc;
  logic [7:0]  p_next_sc;
  logic [31:0] p_profile, p_level, p_setid, p_width, p_height, p_rate, p_units;
  bit          p_sps, p_eg, p_suffix;

  function automatic void elem_fixed(sps_elem_e e, int n);
    p_elem = e; p_eg = 0; p_suffix = 0; p_left = n[7:0]; p_acc = '0;
  endfunction

  function automatic void elem_ue(sps_elem_e e);
    p_elem = e; p_eg = 1; p_suffix = 0; p_lz = '0; p_left = '0; p_acc = '0;
  endfunction

  function automatic logic [31:0] mb_to_px(logic [31:0] v);
    logic [33:0] mbs;
    mbs = {2'b0, v} + 34'd1;
    if (mbs > (34'd1 << MB_BITS)) mbs = 34'd1 << MB_BITS;
    mbs = mbs * 16;
    return (mbs > 34'h7FFF) ? 32'h7FFF : mbs[31:0];
  endfunction

  function automatic void advance_list();
    p_loop++;
    if (p_loop < 8) elem_fixed(ST_LISTFLAG, 1);
    else elem_ue(ST_LOG2FN);
  endfunction

  function automatic void finish_elem(logic [31:0] v);
    logic [7:0] delta;
    case (p_elem)
      ST_HDR: begin
        if (v[4:0] == NAL_SPS) begin p_sps = 1; elem_fixed(ST_PROFILE, 8); end
        else p_elem = ST_DONE;
      end
      ST_PROFILE: begin p_profile = v & 32'hFF; elem_fixed(ST_CONSTR, 8); end
      ST_CONSTR: elem_fixed(ST_LEVEL, 8);
      ST_LEVEL: begin p_level = v & 32'hFF; elem_ue(ST_SPSID); end
      ST_SPSID: begin
        p_setid = (v > 31) ? 31 : v;
        if (p_profile == PRF_HI || p_profile == PRF_HI10 || p_profile == PRF_HI42 ||
            p_profile == PRF_HI44) elem_ue(ST_CHROMA);
        else elem_ue(ST_LOG2FN);
      end
      ST_CHROMA: if (v == 3) elem_fixed(ST_RESID, 1); else elem_ue(ST_BDL);
      ST_RESID: elem_ue(ST_BDL);
      ST_BDL: elem_ue(ST_BDC);
      ST_BDC: elem_fixed(ST_QPBYP, 1);
      ST_QPBYP: elem_fixed(ST_MATRIX, 1);
      ST_MATRIX: begin
        if (v != 0) begin p_loop = 0; elem_fixed(ST_LISTFLAG, 1); end
        else elem_ue(ST_LOG2FN);
      end
      ST_LISTFLAG: begin
        if (v != 0) begin
          p_last_sc = 8; p_next_sc = 8; p_pos = 0; elem_ue(ST_DELTA);
        end else advance_list();
      end
      ST_DELTA: begin
        // Map the code number onto a signed delta, mod 256
        delta = v[0] ? 8'(({1'b0, v} + 33'd1) >> 1) : 8'(32'd0 - (v >> 1));
        p_next_sc = p_last_sc + delta;
        if (p_next_sc != 0) p_last_sc = p_next_sc;
        p_pos++;
        if (p_next_sc == 0 || p_pos >= ((p_loop < 6) ? 16 : 64)) advance_list();
        else elem_ue(ST_DELTA);
      end
      ST_LOG2FN: elem_ue(ST_POCTYPE);
      ST_POCTYPE: begin
        if (v == 0) elem_ue(ST_POCLSB);
        else if (v == 1) elem_fixed(ST_DPOAZ, 1);
        else elem_ue(ST_NUMREF);
      end
      ST_POCLSB: elem_ue(ST_NUMREF);
      ST_DPOAZ: elem_ue(ST_OFFNR);
      ST_OFFNR: elem_ue(ST_OFFTB);
      ST_OFFTB: elem_ue(ST_CYCLE);
      ST_CYCLE: begin
        p_loop = (v > 255) ? 8'd255 : v[7:0];
        if (p_loop == 0) elem_ue(ST_NUMREF); else elem_ue(ST_OFFREF);
      end
      ST_OFFREF: begin
        p_loop--;
        if (p_loop == 0) elem_ue(ST_NUMREF); else elem_ue(ST_OFFREF);
      end
      ST_NUMREF: elem_fixed(ST_GAPS, 1);
      ST_GAPS: elem_ue(ST_WIDTH);
      ST_WIDTH: begin p_width = mb_to_px(v); elem_ue(ST_HEIGHT); end
      ST_HEIGHT: begin p_height = mb_to_px(v); elem_fixed(ST_FMO, 1); end
      ST_FMO: if (v == 0) elem_fixed(ST_MBAFF, 1); else elem_fixed(ST_D8, 1);
      ST_MBAFF: elem_fixed(ST_D8, 1);
      ST_D8: elem_fixed(ST_CROP, 1);
      ST_CROP: begin
        if (v != 0) begin p_loop = 4; elem_ue(ST_CROPOFF); end
        else elem_fixed(ST_VUI, 1);
      end
      ST_CROPOFF: begin
        p_loop--;
        if (p_loop == 0) elem_fixed(ST_VUI, 1); else elem_ue(ST_CROPOFF);
      end
      ST_VUI: if (v != 0) elem_fixed(ST_ARFLAG, 1); else p_elem = ST_DONE;
      ST_ARFLAG: if (v != 0) elem_fixed(ST_ARIDC, 8); else elem_fixed(ST_OVSC, 1);
      ST_ARIDC: if (v == AR_EXT) elem_fixed(ST_SAR, 32); else elem_fixed(ST_OVSC, 1);
      ST_SAR: elem_fixed(ST_OVSC, 1);
      ST_OVSC: if (v != 0) elem_fixed(ST_OVSCAPP, 1); else elem_fixed(ST_VST, 1);
      ST_OVSCAPP: elem_fixed(ST_VST, 1);
      ST_VST: if (v != 0) elem_fixed(ST_VFMT, 5); else elem_fixed(ST_CHLOC, 1);
      ST_VFMT: if (v[0]) elem_fixed(ST_COLOUR, 24); else elem_fixed(ST_CHLOC, 1);
      ST_COLOUR: elem_fixed(ST_CHLOC, 1);
      ST_CHLOC: if (v != 0) elem_ue(ST_CHTOP); else elem_fixed(ST_TIMING, 1);
      ST_CHTOP: elem_ue(ST_CHBOT);
      ST_CHBOT: elem_fixed(ST_TIMING, 1);
      ST_TIMING: if (v != 0) elem_fixed(ST_UNITS, 32); else p_elem = ST_DONE;
      ST_UNITS: begin p_units = v; elem_fixed(ST_SCALE, 32); end
      ST_SCALE: begin
        p_rate = (p_units != 0) ? v / p_units : 0;
        elem_fixed(ST_FIXED, 1);
      end
      ST_FIXED: begin
        if (v != 0) p_rate = p_rate >> 1;
        p_elem = ST_DONE;
      end
      default: p_elem = ST_DONE;
    endcase
  endfunction

  function automatic void take_bit(bit b);
    if (p_elem == ST_DONE) return;
    if (!p_eg || p_suffix) begin
      p_acc = {p_acc[30:0], b};
      p_left--;
      if (p_left == 0) begin
        if (!p_eg) finish_elem(p_acc);
        else finish_elem((p_lz >= 32) ? 32'hFFFF_FFFF
                                     : ((32'd1 << p_lz) - 32'd1) + p_acc);
      end
    end else if (!b) begin
      if (p_lz < 63) p_lz++;
    end else if (p_lz == 0) begin
      finish_elem(0);
    end else begin
      p_suffix = 1; p_left = {2'b0, p_lz}; p_acc = '0;
    end
  endfunction

  function automatic void clear_unit();
    p_zeros = 0; p_lz = 0; p_loop = 0; p_pos = 0; p_last_sc = 8; p_next_sc = 8;
    p_profile = 0; p_level = 0; p_setid = 0; p_width = 0; p_height = 0;
    p_rate = 0; p_units = 0; p_sps = 0;
    elem_fixed(ST_HDR, 8);
  endfunction

  // Run one accepted beat through the predictor; queue the unit summary on last
  function automatic void predict_beat(logic [7:0] b, logic last);
    sps_info_t r;
    bit drop;
    drop = (p_zeros == 2 && b == EP_BYTE);
    if (drop) p_zeros = 0;
    else if (b == 0) p_zeros = (p_zeros < 2) ? p_zeros + 1 : 2;
    else p_zeros = 0;
    if (!drop) for (int i = 7; i >= 0; i--) take_bit(b[i]);
    if (!last) return;
    r.is_sps = p_sps;
    r.width_px = p_width[14:0];
    r.height_px = p_height[14:0];
    r.rate = p_rate;
    r.profile = p_profile[7:0];
    r.level = p_level[7:0];
    r.set_id = p_setid[4:0];
    r.truncated = (p_elem != ST_DONE);
    info_q.push_back(r);
    clear_unit();
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: random stall per beat, check every accepted beat
  int stall_cnt = 0;
  always @(posedge clk) begin
    sps_info_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (info_q.size() == 0) begin
          report("unexpected beat", out_tdata[31:0], 0);
        end else begin
          w = info_q.pop_front();
          if (out_tuser !== w.is_sps) report("is_sps", out_tuser, w.is_sps);
          if (out_tdata[14:0] !== w.width_px) report("width", out_tdata[14:0], w.width_px);
          if (out_tdata[29:15] !== w.height_px)
            report("height", out_tdata[29:15], w.height_px);
          if (out_tdata[61:30] !== w.rate) report("frame_rate", out_tdata[61:30], w.rate);
          if (out_tdata[69:62] !== w.profile) report("profile", out_tdata[69:62], w.profile);
          if (out_tdata[77:70] !== w.level) report("level", out_tdata[77:70], w.level);
          if (out_tdata[82:78] !== w.set_id) report("set_id", out_tdata[82:78], w.set_id);
          if (out_tdata[83] !== w.truncated) report("truncated", out_tdata[83], w.truncated);
          if (out_tdata[87:84] !== 4'b0) report("fill", out_tdata[87:84], 0);
          if (w.is_sps) sps_seen++;
          if (w.truncated) cut_seen++;
        end
        stall_cnt = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Send one beat; called at a rising edge, returns at the accepting edge
  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_beat(b, last);
    bytes_sent++;
  endtask

  task automatic send_unit();
    foreach (unit_bytes[i]) send_beat(unit_bytes[i], i == unit_bytes.size() - 1);
    units_sent++;
  endtask

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bitq.push_back(v[i]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [32:0] x;
    int n;
    x = {1'b0, v} + 33'd1;
    n = 32;
    while (!x[n]) n--;
    repeat (n) bitq.push_back(1'b0);
    for (int i = n; i >= 0; i--) bitq.push_back(x[i]);
  endtask

  // Small code number most of the time, occasionally a wide one
  function automatic logic [31:0] any_ue();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 4095);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic sps_knobs_t roll_knobs();
    sps_knobs_t k;
    logic [7:0] hi[4] = '{PRF_HI, PRF_HI10, PRF_HI42, PRF_HI44};
    k.profile = ($urandom_range(0, 1) == 0) ? hi[$urandom_range(0, 3)] : 8'($urandom);
    k.chroma = $urandom_range(0, 3);
    k.matrix = ($urandom_range(0, 2) == 0);
    k.poc_type = $urandom_range(0, 4);
    k.cycle_len = $urandom_range(0, 5);
    k.set_id = $urandom_range(0, 40);
    k.wmb = ($urandom_range(0, 9) == 0) ? any_ue() : $urandom_range(0, 150);
    k.hmb = ($urandom_range(0, 9) == 0) ? any_ue() : $urandom_range(0, 90);
    k.crop = $urandom_range(0, 1);
    k.vui = ($urandom_range(0, 4) != 0);
    k.ar = $urandom_range(0, 1);
    k.ar_idc = ($urandom_range(0, 1) == 0) ? AR_EXT : 8'($urandom);
    k.vst = $urandom_range(0, 1);
    k.colour = $urandom_range(0, 1);
    k.chloc = $urandom_range(0, 1);
    k.timing = ($urandom_range(0, 4) != 0);
    k.units = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 1) == 0) ?
              $urandom_range(1, 3000) : $urandom);
    k.tscale = $urandom;
    k.fixed = $urandom_range(0, 1);
    k.cut = 0;
    k.junk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    return k;
  endfunction

  // Serialize one SPS into unit_bytes, with emulation prevention
  task automatic build_sps(sps_knobs_t k);
    logic [7:0] raw[$];
    logic [7:0] b;
    int zr, step, size, len;
    logic [7:0] last_sc, nxt;
    bitq.delete();
    put_bits({24'b0, 3'($urandom_range(0, 7)), NAL_SPS}, 8);
    put_bits({24'b0, k.profile}, 8);
    put_bits($urandom, 8);
    put_bits($urandom, 8);
    put_ue(k.set_id);
    if (k.profile == PRF_HI || k.profile == PRF_HI10 || k.profile == PRF_HI42 ||
        k.profile == PRF_HI44) begin
      put_ue(k.chroma);
      if (k.chroma == 3) put_bits($urandom, 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_bits($urandom, 1);
      put_bits(k.matrix, 1);
      if (k.matrix) for (int l = 0; l < 8; l++) begin
        put_bits($urandom_range(0, 1), 1);
        if (bitq[bitq.size() - 1]) begin
          size = (l < 6) ? 16 : 64;
          last_sc = 8;
          for (int j = 0; j < size; j++) begin
            // End the list with a zero scale now and then
            if ($urandom_range(0, 15) == 0) begin
              put_ue({23'b0, last_sc, 1'b0});
              break;
            end
            step = $urandom_range(0, 7);
            put_ue(step);
            nxt = last_sc + (step[0] ? 8'((step + 1) >> 1) : 8'(-(step >> 1)));
            if (nxt == 0) break;
            last_sc = nxt;
          end
        end
      end
    end
    put_ue($urandom_range(0, 12));
    put_ue(k.poc_type);
    if (k.poc_type == 0) put_ue($urandom_range(0, 12));
    else if (k.poc_type == 1) begin
      put_bits($urandom, 1);
      put_ue(any_ue());
      put_ue(any_ue());
      put_ue(k.cycle_len);
      repeat (k.cycle_len) put_ue(any_ue());
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom, 1);
    put_ue(k.wmb);
    put_ue(k.hmb);
    put_bits($urandom_range(0, 1), 1);
    if (!bitq[bitq.size() - 1]) put_bits($urandom, 1);
    put_bits($urandom, 1);
    put_bits(k.crop, 1);
    if (k.crop) repeat (4) put_ue(any_ue());
    put_bits(k.vui, 1);
    if (k.vui) begin
      put_bits(k.ar, 1);
      if (k.ar) begin
        put_bits({24'b0, k.ar_idc}, 8);
        if (k.ar_idc == AR_EXT) put_bits($urandom, 32);
      end
      put_bits($urandom_range(0, 1), 1);
      if (bitq[bitq.size() - 1]) put_bits($urandom, 1);
      put_bits(k.vst, 1);
      if (k.vst) begin
        put_bits({27'b0, 4'($urandom_range(0, 15)), k.colour}, 5);
        if (k.colour) put_bits($urandom, 24);
      end
      put_bits(k.chloc, 1);
      if (k.chloc) begin put_ue(any_ue()); put_ue(any_ue()); end
      put_bits(k.timing, 1);
      if (k.timing) begin
        put_bits(k.units, 32);
        put_bits(k.tscale, 32);
        put_bits(k.fixed, 1);
      end
    end
    // Stop bit, then pad to a byte boundary
    bitq.push_back(1'b1);
    while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
    for (int i = 0; i < bitq.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7 - j] = bitq[i + j];
      raw.push_back(b);
    end
    repeat (k.junk) raw.push_back($urandom);
    unit_bytes.delete();
    zr = 0;
    foreach (raw[i]) begin
      if (zr == 2 && raw[i] <= EP_BYTE) begin
        unit_bytes.push_back(EP_BYTE);
        zr = 0;
      end
      unit_bytes.push_back(raw[i]);
      zr = (raw[i] == 0) ? zr + 1 : 0;
    end
    len = unit_bytes.size();
    if (k.cut > 0 && k.cut < len) unit_bytes = unit_bytes[0:k.cut - 1];
  endtask

  // Drop the input valid, then hold until every expected result has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (info_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    sps_knobs_t k;
    // Header-only units of other types, and a bare SPS header cut after one byte
    unit_bytes = '{8'h65}; send_unit();
    unit_bytes = '{8'hFF}; send_unit();
    unit_bytes = '{8'h67}; send_unit();
    // Every picture order count type, including one above 2
    for (int t = 0; t <= 3; t++) begin
      k = roll_knobs(); k.poc_type = t; k.cycle_len = (t == 1) ? 3 : 0; k.junk = 0;
      build_sps(k); send_unit();
    end
    // High profile with scaling lists, chroma 3 with the residual flag
    k = roll_knobs(); k.profile = PRF_HI44; k.chroma = 3; k.matrix = 1;
    build_sps(k); send_unit();
    // Full VUI with extended aspect ratio, fixed rate
    k = roll_knobs(); k.vui = 1; k.ar = 1; k.ar_idc = AR_EXT; k.vst = 1; k.colour = 1;
    k.chloc = 1; k.timing = 1; k.units = 1001; k.tscale = 60000; k.fixed = 1;
    build_sps(k); send_unit();
    // Zero divisor, and the widest divide
    k = roll_knobs(); k.vui = 1; k.timing = 1; k.units = 0; build_sps(k); send_unit();
    k = roll_knobs(); k.vui = 1; k.timing = 1; k.units = 1; k.tscale = 32'hFFFF_FFFF;
    k.fixed = 0; build_sps(k); send_unit();
    // Oversized sizes and a saturated set id
    k = roll_knobs(); k.wmb = 32'hFFFF_FFFE; k.hmb = 5000; k.set_id = 32'hFFFF_FFFE;
    build_sps(k); send_unit();
    k = roll_knobs(); k.wmb = 1023; k.hmb = 1024; k.set_id = 31; build_sps(k); send_unit();
    // Long exp-Golomb code: 32 or more prefix zeros
    unit_bytes = '{8'h67, 8'h42, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00,
                   8'h03, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80};
    send_unit();
    // Early end in the middle of the syntax, and trailing bytes after it
    k = roll_knobs(); k.cut = 6; build_sps(k); send_unit();
    k = roll_knobs(); k.junk = 3; build_sps(k); send_unit();
    // Prevention byte pattern inside a unit of another type
    unit_bytes = '{8'h01, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03, 8'h03}; send_unit();
  endtask

  task automatic test_random_units(int target);
    sps_knobs_t k;
    int n;
    while (bytes_sent < target) begin
      // Stretches with no idling on either side
      no_idle = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 19))
        0, 1: begin
          n = $urandom_range(1, 12);
          unit_bytes.delete();
          repeat (n) unit_bytes.push_back($urandom);
        end
        2, 3, 4: begin
          k = roll_knobs(); build_sps(k);
          k.cut = $urandom_range(1, unit_bytes.size()); build_sps(k);
        end
        default: begin k = roll_knobs(); build_sps(k); end
      endcase
      send_unit();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    sps_knobs_t k;
    k = roll_knobs(); build_sps(k); send_unit();
    wait_drained();
    k = roll_knobs(); build_sps(k); send_unit();
  endtask

  initial begin
    clear_unit();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random_units(bytes_sent + 1800);
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d units in %0d beats; %0d SPS results, %0d cut short.",
             units_sent, bytes_sent, sps_seen, cut_seen);
    if (errors == 0 && info_q.size() == 0) begin
      $display("tb_h264_sps_header_parser passed");
    end else begin
      $display("tb_h264_sps_header_parser failed");
    end
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("Timeout with %0d results outstanding.", info_q.size());
    $display("tb_h264_sps_header_parser failed");
    $finish;
  end

endmodule
